FILE: hw/rtl/gst_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package gst_pkg;

   localparam int GST_CHANNELS = 8;
   localparam int GST_GROOVES  = 32;

   localparam int STEP_W      = 4;
   localparam int ENTRY_W     = 8;
   localparam int GIDX_W      = 8;
   localparam int CHAN_W      = 3;
   localparam int KIND_W      = 3;
   localparam int RES_GROOVE_W = 5;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [ENTRY_W-1:0] END_MARK      = 8'hFF;
   localparam logic [ENTRY_W-1:0] DEFAULT_TICKS = 8'd6;

   // Request kinds carried on req_tuser
   localparam logic [KIND_W-1:0] REQ_TICK      = 3'd0;
   localparam logic [KIND_W-1:0] REQ_SET       = 3'd1;
   localparam logic [KIND_W-1:0] REQ_RESET_POS = 3'd2;
   localparam logic [KIND_W-1:0] REQ_WRITE     = 3'd3;
   localparam logic [KIND_W-1:0] REQ_QUERY     = 3'd4;

   // Table read address selects
   localparam logic [1:0] RD_NEXT  = 2'd0;  // channel groove, position + 1
   localparam logic [1:0] RD_FIRST = 2'd1;  // channel groove, entry 0
   localparam logic [1:0] RD_CUR   = 2'd2;  // channel groove, current position
   localparam logic [1:0] RD_REQ   = 2'd3;  // requested groove, entry 0

   typedef struct packed {
      logic       capture;       // latch the request word, clear results
      logic       clr_write;     // write one entry of the clearing pass
      logic       tbl_write;     // write the requested table entry
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       sel_req_chan;  // address channel from request, else walker
      logic       walk_clear;
      logic       walk_inc;
      logic       tick_dec;
      logic       step_load;
      logic       step_wrap;
      logic       set_load;
      logic       pos_clear;
      logic       rem_start;
      logic       qry_load;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] req_kind;
      logic              groove_ok;
      logic              chan_ok;
      logic              ticks_zero;
      logic              entry_end;
      logic              walk_last;
      logic              rem_done;
      logic              rsp_busy;
      logic              clr_last;
   } status_type;

endpackage

FILE: hw/rtl/gst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gst_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gst_rem.sv
// Bit-serial 8-bit remainder unit, one dividend bit per cycle.
module gst_rem
   import gst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ENTRY_W-1:0] dividend,
   input  logic [ENTRY_W-1:0] divisor,
   output logic               done,
   output logic [ENTRY_W-1:0] rem
);

   logic [ENTRY_W-1:0] quo_ff, quo_in;
   logic [ENTRY_W-1:0] div_ff, div_in;
   logic [ENTRY_W-1:0] rem_ff, rem_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ENTRY_W:0]   shifted;

   always_comb begin
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[ENTRY_W-1]};
      if (start) begin
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = ENTRY_W'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = shifted[ENTRY_W-1:0];
         end
         quo_in = {quo_ff[ENTRY_W-2:0], 1'b0};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: hw/rtl/gst_datapath.sv
// Datapath: request capture, channel state, groove table, result register.
module gst_datapath
   import gst_pkg::*;
#(
   parameter int CHANNELS = GST_CHANNELS,
   parameter int GROOVES  = GST_GROOVES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [REQ_TDATA_W-1:0] req_word,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int GW    = (GROOVES > 1) ? $clog2(GROOVES) : 1;
   localparam int AW    = GW + STEP_W;
   localparam int DEPTH = GROOVES * 16;

   // captured request word
   logic [KIND_W-1:0]  kind_ff;
   logic [CHAN_W-1:0]  chan_ff;
   logic [GIDX_W-1:0]  gidx_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [ENTRY_W-1:0] val_ff;

   // channel state
   logic [GW-1:0]      groove_ff [CHANNELS];
   logic [GW-1:0]      groove_in [CHANNELS];
   logic [STEP_W-1:0]  pos_ff    [CHANNELS];
   logic [STEP_W-1:0]  pos_in    [CHANNELS];
   logic [ENTRY_W-1:0] ticks_ff  [CHANNELS];
   logic [ENTRY_W-1:0] ticks_in  [CHANNELS];

   logic [CW-1:0]      walk_ff, walk_in;
   logic [AW-1:0]      clr_ff, clr_in;

   logic [7:0]              mask_ff, mask_in;
   logic                    trig_ff, trig_in;
   logic [RES_GROOVE_W-1:0] res_groove_ff, res_groove_in;
   logic [STEP_W-1:0]       res_pos_ff, res_pos_in;
   logic                    ent_nz_ff, ent_nz_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [CW-1:0]      idx;
   logic [GW-1:0]      cur_groove;
   logic [STEP_W-1:0]  cur_pos;
   logic [ENTRY_W-1:0] cur_ticks;
   logic [7:0]         groove_ext;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   logic               rem_done;
   logic [ENTRY_W-1:0] rem_val;

   assign idx        = cmd.sel_req_chan ? chan_ff[CW-1:0] : walk_ff;
   assign cur_groove = groove_ff[idx];
   assign cur_pos    = pos_ff[idx];
   assign cur_ticks  = ticks_ff[idx];
   assign groove_ext = 8'(cur_groove);

   always_comb begin
      case (cmd.rd_sel)
         RD_NEXT:  ram_raddr = {cur_groove, STEP_W'(cur_pos + 4'd1)};
         RD_FIRST: ram_raddr = {cur_groove, {STEP_W{1'b0}}};
         RD_CUR:   ram_raddr = {cur_groove, cur_pos};
         RD_REQ:   ram_raddr = {gidx_ff[GW-1:0], {STEP_W{1'b0}}};
         default:  ram_raddr = {cur_groove, cur_pos};
      endcase
   end

   // clearing pass: entries 0 and 1 of each groove get the default count
   assign ram_we    = cmd.clr_write | cmd.tbl_write;
   assign ram_waddr = cmd.clr_write ? clr_ff : {gidx_ff[GW-1:0], step_ff};
   assign ram_wdata = cmd.clr_write
                      ? ((clr_ff[STEP_W-1:1] == 3'd0) ? DEFAULT_TICKS : END_MARK)
                      : val_ff;

   gst_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   gst_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.rem_start),
      .dividend (cur_ticks),
      .divisor  (ram_rdata),
      .done     (rem_done),
      .rem      (rem_val)
   );

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         groove_in[c] = groove_ff[c];
         pos_in[c]    = pos_ff[c];
         ticks_in[c]  = ticks_ff[c];
      end
      if (cmd.tick_dec) begin
         ticks_in[idx] = cur_ticks - 8'd1;
      end
      if (cmd.step_load) begin
         pos_in[idx]   = cur_pos + 4'd1;
         ticks_in[idx] = ram_rdata - 8'd1;
      end
      if (cmd.step_wrap) begin
         pos_in[idx]   = '0;
         ticks_in[idx] = ram_rdata - 8'd1;
      end
      if (cmd.set_load) begin
         groove_in[idx] = gidx_ff[GW-1:0];
         pos_in[idx]    = '0;
         ticks_in[idx]  = ram_rdata;
      end
      if (cmd.pos_clear) begin
         pos_in[idx]   = '0;
         ticks_in[idx] = ram_rdata;
      end
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_clear) begin
         walk_in = '0;
      end else if (cmd.walk_inc) begin
         walk_in = walk_ff + CW'(1);
      end
      clr_in = cmd.clr_write ? clr_ff + AW'(1) : clr_ff;
   end

   always_comb begin
      mask_in       = mask_ff;
      trig_in       = trig_ff;
      res_groove_in = res_groove_ff;
      res_pos_in    = res_pos_ff;
      ent_nz_in     = ent_nz_ff;
      if (cmd.capture) begin
         mask_in       = '0;
         trig_in       = 1'b0;
         res_groove_in = '0;
         res_pos_in    = '0;
      end
      if (cmd.step_load || cmd.step_wrap) begin
         mask_in = mask_ff | (8'd1 << walk_ff);
      end
      if (cmd.rem_start) begin
         ent_nz_in = (ram_rdata != 8'd0);
      end
      if (cmd.qry_load) begin
         trig_in       = ent_nz_ff && (rem_val == 8'd0);
         res_groove_in = groove_ext[RES_GROOVE_W-1:0];
         res_pos_in    = cur_pos;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, res_pos_ff, res_groove_ff, trig_ff, mask_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            groove_ff[c] <= '0;
            pos_ff[c]    <= '0;
            ticks_ff[c]  <= DEFAULT_TICKS;
         end
         walk_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            groove_ff[c] <= groove_in[c];
            pos_ff[c]    <= pos_in[c];
            ticks_ff[c]  <= ticks_in[c];
         end
         walk_ff      <= walk_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) begin
         kind_ff <= req_kind;
         chan_ff <= req_word[2:0];
         gidx_ff <= req_word[10:3];
         step_ff <= req_word[14:11];
         val_ff  <= req_word[22:15];
      end
      mask_ff       <= mask_in;
      trig_ff       <= trig_in;
      res_groove_ff <= res_groove_in;
      res_pos_ff    <= res_pos_in;
      ent_nz_ff     <= ent_nz_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign status.req_kind   = kind_ff;
   assign status.groove_ok  = (gidx_ff < 8'(GROOVES));
   assign status.chan_ok    = ({1'b0, chan_ff} < 4'(CHANNELS));
   assign status.ticks_zero = (cur_ticks == 8'd0);
   assign status.entry_end  = (ram_rdata == END_MARK);
   assign status.walk_last  = (walk_ff == CW'(CHANNELS - 1));
   assign status.rem_done   = rem_done;
   assign status.rsp_busy   = rsp_valid_ff;
   assign status.clr_last   = (clr_ff == AW'(DEPTH - 1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hw/rtl/gst_ctrl.sv
// Controller: sequences table clearing, channel walks, queries and results.
module gst_ctrl
   import gst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DECODE    = 4'd2;
   localparam logic [3:0] S_CH_CHECK  = 4'd3;
   localparam logic [3:0] S_CH_RD1    = 4'd4;
   localparam logic [3:0] S_CH_RD2    = 4'd5;
   localparam logic [3:0] S_SET_RD    = 4'd6;
   localparam logic [3:0] S_RST_ISSUE = 4'd7;
   localparam logic [3:0] S_RST_WR    = 4'd8;
   localparam logic [3:0] S_QRY_RD    = 4'd9;
   localparam logic [3:0] S_QRY_DIV   = 4'd10;
   localparam logic [3:0] S_FIN       = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.sel_req_chan = 1'b1;
            case (status.req_kind)
               REQ_TICK: begin
                  cmd.walk_clear = 1'b1;
                  state_in       = S_CH_CHECK;
               end
               REQ_SET: begin
                  if (status.groove_ok && status.chan_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_REQ;
                     state_in   = S_SET_RD;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               REQ_RESET_POS: begin
                  cmd.walk_clear = 1'b1;
                  state_in       = S_RST_ISSUE;
               end
               REQ_WRITE: begin
                  cmd.tbl_write = status.groove_ok;
                  state_in      = S_FIN;
               end
               REQ_QUERY: begin
                  if (status.chan_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_CUR;
                     state_in   = S_QRY_RD;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_CH_CHECK: begin
            if (status.ticks_zero) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = S_CH_RD1;
            end else begin
               cmd.tick_dec = 1'b1;
               cmd.walk_inc = !status.walk_last;
               state_in     = status.walk_last ? S_FIN : S_CH_CHECK;
            end
         end
         S_CH_RD1: begin
            // end marker: fetch entry 0 and wrap
            if (status.entry_end) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_FIRST;
               state_in   = S_CH_RD2;
            end else begin
               cmd.step_load = 1'b1;
               cmd.walk_inc  = !status.walk_last;
               state_in      = status.walk_last ? S_FIN : S_CH_CHECK;
            end
         end
         S_CH_RD2: begin
            cmd.step_wrap = 1'b1;
            cmd.walk_inc  = !status.walk_last;
            state_in      = status.walk_last ? S_FIN : S_CH_CHECK;
         end
         S_SET_RD: begin
            cmd.sel_req_chan = 1'b1;
            cmd.set_load     = 1'b1;
            state_in         = S_FIN;
         end
         S_RST_ISSUE: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_FIRST;
            state_in   = S_RST_WR;
         end
         S_RST_WR: begin
            cmd.pos_clear = 1'b1;
            cmd.walk_inc  = !status.walk_last;
            state_in      = status.walk_last ? S_FIN : S_RST_ISSUE;
         end
         S_QRY_RD: begin
            cmd.sel_req_chan = 1'b1;
            cmd.rem_start    = 1'b1;
            state_in         = S_QRY_DIV;
         end
         S_QRY_DIV: begin
            cmd.sel_req_chan = 1'b1;
            if (status.rem_done) begin
               cmd.qry_load = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the result register is free
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/groove_step_timer_core.sv
// Top level of the per-channel groove step timer.
// Swing timer for a sequencer: each request word yields exactly one response
// word. After reset a clearing pass writes all GROOVES*16 table entries (512
// at the default size) before the first request is taken. A tick walks the
// channels one at a time through the single table read port: a channel that
// only counts down reads nothing, one that steps reads its next entry, and one
// that wraps on an end marker also reads entry 0. Reset positions reads entry
// 0 of each channel's groove in turn. A query waits for the bit-serial
// remainder unit. A new request is accepted while the previous response still
// waits in the output register.
module groove_step_timer_core
   import gst_pkg::*;
#(
   parameter int CHANNELS = GST_CHANNELS,
   parameter int GROOVES  = GST_GROOVES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // chan[2:0], groove_index[10:3], step_index[14:11], entry_value[22:15]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[2:0]
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // stepped_mask[7:0], trigger_now[8], cur_groove[13:9], cur_position[17:14]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   gst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gst_datapath #(
      .CHANNELS (CHANNELS),
      .GROOVES  (GROOVES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_kind   (req_tuser),
      .req_word   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/groove_step_timer_core_tb.sv
// Self-checking testbench for the groove step timer core: table-driven and random requests.
`timescale 1ns / 1ps

module groove_step_timer_core_tb;
   import gst_pkg::*;

   // request kinds the block answers with an all-zero word
   localparam logic [KIND_W-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [KIND_W-1:0] REQ_SPARE_C = 3'd7;

   localparam int HOLD_CYCLES   = 400;
   localparam int BACKLOG_ITEMS = 40;
   localparam int PHASE_ITEMS   = 480;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic [7:0] stepped;
      logic       trigger;
      logic [4:0] groove;
      logic [3:0] position;
   } timer_rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [2:0]        ch;
      logic [7:0]        gi;
      logic [3:0]        si;
      logic [7:0]        val;
      logic              typed;
      logic [7:0]        x_stepped;
      logic              x_trigger;
      logic [4:0]        x_groove;
      logic [3:0]        x_position;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // predictor state
   logic [7:0] groove_tbl [GST_GROOVES][16];
   logic [4:0] ch_groove [GST_CHANNELS];
   logic [3:0] ch_pos [GST_CHANNELS];
   logic [7:0] ch_ticks [GST_CHANNELS];

   timer_rsp_type pending_rsp [$];

   int errors = 0;
   int words_seen = 0;
   int stepping_ticks = 0;
   int ticks_sent = 0;
   int queries_sent = 0;
   int items_sent = 0;
   int send_idle = 0;
   int recv_idle = 0;
   logic backlog_on = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   probe_row_type probe_rows [0:21] = '{
      '{REQ_QUERY,     3'd0, 8'd0,   4'd0,  8'd0,   1'b1, 8'h00, 1'b1, 5'd0, 4'd0},
      '{REQ_QUERY,     3'd7, 8'd255, 4'd15, 8'd255, 1'b1, 8'h00, 1'b1, 5'd0, 4'd0},
      '{REQ_TICK,      3'd0, 8'd0,   4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_SPARE_C,   3'd7, 8'd255, 4'd15, 8'd255, 1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_SPARE_A,   3'd0, 8'd0,   4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_SET,       3'd7, 8'd255, 4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_SET,       3'd0, 8'd32,  4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_WRITE,     3'd0, 8'd32,  4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_WRITE,     3'd0, 8'd31,  4'd0,  8'd1,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      // zero entry: a step onto it reloads zero and wraps to 255
      '{REQ_WRITE,     3'd0, 8'd31,  4'd1,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_WRITE,     3'd0, 8'd31,  4'd15, 8'd255, 1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_SET,       3'd7, 8'd31,  4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_QUERY,     3'd7, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_TICK,      3'd0, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_TICK,      3'd0, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_QUERY,     3'd7, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_WRITE,     3'd0, 8'd0,   4'd2,  8'd2,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_SET,       3'd3, 8'd0,   4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_RESET_POS, 3'd0, 8'd0,   4'd0,  8'd0,   1'b1, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_QUERY,     3'd3, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_TICK,      3'd0, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0},
      '{REQ_QUERY,     3'd7, 8'd0,   4'd0,  8'd0,   1'b0, 8'h00, 1'b0, 5'd0, 4'd0}
   };

   groove_step_timer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic timer_rsp_type timer_predict(input logic [KIND_W-1:0] kind,
                                                input logic [2:0] ch, input logic [7:0] gi,
                                                input logic [3:0] si, input logic [7:0] val);
      timer_rsp_type r;
      logic [3:0] p;
      logic [7:0] e;
      r = '0;
      case (kind)
         REQ_TICK: begin
            for (int c = 0; c < GST_CHANNELS; c++) begin
               if (ch_ticks[c] == 8'd0) begin
                  p = ch_pos[c] + 4'd1;
                  if (groove_tbl[ch_groove[c]][p] == END_MARK)
                     p = 4'd0;
                  ch_pos[c] = p;
                  ch_ticks[c] = groove_tbl[ch_groove[c]][p];
                  r.stepped[c] = 1'b1;
               end
               ch_ticks[c] = ch_ticks[c] - 8'd1;
            end
         end
         REQ_SET: begin
            if (gi < GST_GROOVES) begin
               ch_groove[ch] = gi[4:0];
               ch_pos[ch] = 4'd0;
               ch_ticks[ch] = groove_tbl[gi[4:0]][0];
            end
         end
         REQ_RESET_POS: begin
            for (int c = 0; c < GST_CHANNELS; c++) begin
               ch_pos[c] = 4'd0;
               ch_ticks[c] = groove_tbl[ch_groove[c]][0];
            end
         end
         REQ_WRITE: begin
            if (gi < GST_GROOVES)
               groove_tbl[gi[4:0]][si] = val;
         end
         REQ_QUERY: begin
            e = groove_tbl[ch_groove[ch]][ch_pos[ch]];
            if (e != 8'd0)
               r.trigger = (ch_ticks[ch] % e) == 8'd0;
            r.groove = ch_groove[ch];
            r.position = ch_pos[ch];
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one request word after an optional gap and record what it should answer.
   task automatic push_word(input logic [KIND_W-1:0] kind, input logic [2:0] ch,
                            input logic [7:0] gi, input logic [3:0] si, input logic [7:0] val,
                            input logic typed, input timer_rsp_type typed_rsp);
      timer_rsp_type want;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, val, si, gi, ch};
      do @(posedge clock); while (!req_tready);
      want = timer_predict(kind, ch, gi, si, val);
      pending_rsp.push_back(typed ? typed_rsp : want);
      items_sent++;
      if (kind == REQ_TICK) ticks_sent++;
      if (kind == REQ_QUERY) queries_sent++;
   endtask

   // Drop valid and hold until every expected word has come back.
   task automatic settle_out;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      timer_rsp_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.stepped = rsp_tdata[7:0];
            seen.trigger = rsp_tdata[8];
            seen.groove = rsp_tdata[13:9];
            seen.position = rsp_tdata[17:14];
            words_seen++;
            if (seen.stepped != 8'd0) stepping_ticks++;
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected word %h", $realtime, rsp_tdata);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (seen.stepped !== want.stepped) begin
                  $display("%0t: stepped_mask expected %h got %h",
                           $realtime, want.stepped, seen.stepped);
                  errors++;
               end
               if (seen.trigger !== want.trigger) begin
                  $display("%0t: trigger_now expected %b got %b",
                           $realtime, want.trigger, seen.trigger);
                  errors++;
               end
               if (seen.groove !== want.groove) begin
                  $display("%0t: cur_groove expected %0d got %0d",
                           $realtime, want.groove, seen.groove);
                  errors++;
               end
               if (seen.position !== want.position) begin
                  $display("%0t: cur_position expected %0d got %0d",
                           $realtime, want.position, seen.position);
                  errors++;
               end
            end
         end
         // hold off once for a long stretch so the block backs up
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (backlog_on && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   initial begin : stimulus
      int pick;
      logic [KIND_W-1:0] k;
      logic [2:0] c;
      logic [7:0] g, v;
      logic [3:0] s;
      probe_row_type row;

      for (int gr = 0; gr < GST_GROOVES; gr++) begin
         for (int st = 0; st < 16; st++)
            groove_tbl[gr][st] = (st < 2) ? DEFAULT_TICKS : END_MARK;
      end
      for (int ch = 0; ch < GST_CHANNELS; ch++) begin
         ch_groove[ch] = 5'd0;
         ch_pos[ch] = 4'd0;
         ch_ticks[ch] = DEFAULT_TICKS;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         push_word(row.kind, row.ch, row.gi, row.si, row.val, row.typed,
                   {row.x_stepped, row.x_trigger, row.x_groove, row.x_position});
      end
      settle_out();

      // back up the block behind a stalled receiver, sender never idles
      send_idle = 0;
      backlog_on <= 1'b1;
      for (int i = 0; i < BACKLOG_ITEMS; i++)
         push_word(REQ_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 1'b0, '0);
      settle_out();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 27 : (ph == 1) ? 87 : 0;
         recv_idle <= (ph == 0) ? 87 : (ph == 1) ? 27 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            c = 3'($urandom_range(0, 7));
            g = 8'($urandom_range(0, 255));
            s = 4'($urandom_range(0, 15));
            v = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            // keep most traffic on a few grooves with short entries
            if (pick < 45) begin
               k = REQ_TICK;
            end else if (pick < 60) begin
               k = REQ_QUERY;
            end else if (pick < 88) begin
               k = (pick < 75) ? REQ_WRITE : REQ_SET;
               g = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, GST_GROOVES - 1));
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  v = 8'($urandom_range(0, 7));
               else if (pick < 85)
                  v = END_MARK;
            end else if (pick < 93) begin
               k = REQ_RESET_POS;
            end else if (pick < 96) begin
               k = 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
            end else begin
               k = $urandom_range(0, 1) ? REQ_SET : REQ_WRITE;
               g = 8'($urandom_range(GST_GROOVES, 255));
            end
            push_word(k, c, g, s, v, 1'b0, '0);
         end
         settle_out();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $realtime, pending_rsp.size());
         errors++;
      end
      $display("run: %0d requests (%0d ticks, %0d queries), %0d words checked",
               items_sent, ticks_sent, queries_sent, words_seen);
      $display("run: %0d ticks stepped a channel, %0d mismatches", stepping_ticks, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
